FILE: hw/rtl/nnfs_pkg.sv
// Shared constants, types and helper functions for the nearest-neighbor frame scaler.
package nnfs_pkg;

  localparam int unsigned MAX_SRC_WIDTH_DEF  = 256;
  localparam int unsigned MAX_SRC_HEIGHT_DEF = 256;
  localparam int unsigned CHANNEL_FRAC_BITS  = 14;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CH_IN_W    = 16;
  localparam int unsigned CH_OUT_W   = 15;
  localparam int unsigned SRC_SZ_W   = 9;
  localparam int unsigned DST_SZ_W   = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PROD_W     = COORD_W + SRC_SZ_W;
  localparam int unsigned REM_W      = DST_SZ_W + 1;
  localparam int unsigned STEP_W     = $clog2(SRC_SZ_W);
  localparam int unsigned PIX_W      = 3 * CH_OUT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [SRC_SZ_W-1:0] SRC_SZ_RST = 9'd256;
  localparam logic [DST_SZ_W-1:0] DST_SZ_RST = 13'd256;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  localparam logic signed [17:0] CH_ONE = $signed(18'(1 << CHANNEL_FRAC_BITS));

  typedef struct packed {
    logic clear;
    logic capture;
    logic decode;
    logic mul_load;
    logic div_step;
    logic addr_load;
    logic rd_en;
    logic out_load;
    logic axis_y;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_dst;
    logic clear_last;
    logic out_free;
  } dp_status_t;

  // Q2.14 channel limited to 0..1.0, kept to the output width.
  function automatic logic [CH_OUT_W-1:0] clamp_ch(input logic signed [CH_IN_W-1:0] v);
    logic signed [17:0] ext;
    logic signed [17:0] lim;
    ext = 18'(v);
    if (ext < 18'sd0) begin
      lim = 18'sd0;
    end else if (ext > CH_ONE) begin
      lim = CH_ONE;
    end else begin
      lim = ext;
    end
    return lim[CH_OUT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/nnfs_intf.sv
// Item channel interfaces: pixel request in, resampled pixel out.
interface nnfs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic [nnfs_pkg::COORD_W-1:0]          coord_x;
  logic [nnfs_pkg::COORD_W-1:0]          coord_y;
  logic signed [nnfs_pkg::CH_IN_W-1:0]   red_in;
  logic signed [nnfs_pkg::CH_IN_W-1:0]   green_in;
  logic signed [nnfs_pkg::CH_IN_W-1:0]   blue_in;

  modport source (output valid, func, coord_x, coord_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, func, coord_x, coord_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface nnfs_out_if;
  logic                           valid;
  logic                           ready;
  logic [nnfs_pkg::CH_OUT_W-1:0]  red_out;
  logic [nnfs_pkg::CH_OUT_W-1:0]  green_out;
  logic [nnfs_pkg::CH_OUT_W-1:0]  blue_out;
  logic                           in_range;

  modport source (output valid, red_out, green_out, blue_out, in_range, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, in_range, output ready);
endinterface

FILE: hw/rtl/nearest_neighbor_frame_scaler.sv
// Top level of the nearest-neighbor frame scaler: frame store with resampled reads.
//
//   channel   dir   handshake            payload
//   req_i     in    valid/ready          func, coord_x, coord_y, red_in, green_in, blue_in
//   rsp_o     out   valid/ready          red_out, green_out, blue_out, in_range
//   cfg       in    cfg_we_i, no wait    cfg_idx_i, cfg_data_i
//
// A write item is accepted, then stored; a read item runs through decode, two multiply
// loads and two 9-step passes of the shared restoring divider, address, RAM read and
// response. An out-of-range read goes from decode straight to the response.
// After reset a clearing pass writes black to all MAX_SRC_WIDTH*MAX_SRC_HEIGHT entries,
// one a cycle (65536 entries by default), with req_i.ready low.
// Results sit in an output register; a stall on rsp_o holds only the response step.
module nearest_neighbor_frame_scaler #(
  parameter int unsigned MAX_SRC_WIDTH  = nnfs_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = nnfs_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [nnfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nnfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  nnfs_in_if.sink                          req_i,
  nnfs_out_if.source                       rsp_o
);

  nnfs_pkg::ctrl_cmd_t   cmd;
  nnfs_pkg::dp_status_t  status;
  logic                  in_ready;

  assign req_i.ready = in_ready;

  nnfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nnfs_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .func_i      (req_i.func),
    .coord_x_i   (req_i.coord_x),
    .coord_y_i   (req_i.coord_y),
    .red_in_i    (req_i.red_in),
    .green_in_i  (req_i.green_in),
    .blue_in_i   (req_i.blue_in),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .red_out_o   (rsp_o.red_out),
    .green_out_o (rsp_o.green_out),
    .blue_out_o  (rsp_o.blue_out),
    .in_range_o  (rsp_o.in_range)
  );

endmodule

FILE: hw/rtl/nnfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nnfs_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/nnfs_dp.sv
// Datapath: config registers, item registers, shared multiplier and divider, pixel store.
module nnfs_dp #(
  parameter int unsigned MAX_SRC_WIDTH  = nnfs_pkg::MAX_SRC_WIDTH_DEF,
  parameter int unsigned MAX_SRC_HEIGHT = nnfs_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [nnfs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [nnfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 func_i,
  input  logic [nnfs_pkg::COORD_W-1:0]         coord_x_i,
  input  logic [nnfs_pkg::COORD_W-1:0]         coord_y_i,
  input  logic signed [nnfs_pkg::CH_IN_W-1:0]  red_in_i,
  input  logic signed [nnfs_pkg::CH_IN_W-1:0]  green_in_i,
  input  logic signed [nnfs_pkg::CH_IN_W-1:0]  blue_in_i,
  input  nnfs_pkg::ctrl_cmd_t                  cmd_i,
  output nnfs_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [nnfs_pkg::CH_OUT_W-1:0]        red_out_o,
  output logic [nnfs_pkg::CH_OUT_W-1:0]        green_out_o,
  output logic [nnfs_pkg::CH_OUT_W-1:0]        blue_out_o,
  output logic                                 in_range_o
);

  localparam int unsigned DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = nnfs_pkg::SRC_SZ_W;
  localparam int unsigned CW    = nnfs_pkg::COORD_W;
  localparam int unsigned OW    = nnfs_pkg::CH_OUT_W;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] r, input int unsigned mx);
    logic [SW-1:0] e;
    if (r == '0) begin
      e = SW'(1);
    end else if (32'(r) > mx) begin
      e = SW'(mx);
    end else begin
      e = r;
    end
    return e;
  endfunction

  function automatic logic [SW-1:0] lim_idx(input logic [SW-1:0] q, input logic [SW-1:0] s);
    logic [SW-1:0] m;
    m = s - SW'(1);
    return (q > m) ? m : q;
  endfunction

  function automatic logic [AW-1:0] lin_addr(input logic [CW-1:0] row, input logic [CW-1:0] col);
    logic [31:0] s;
    s = 32'(row) * 32'(MAX_SRC_WIDTH) + 32'(col);
    return s[AW-1:0];
  endfunction

  logic [SW-1:0]                  src_w_q, src_h_q;
  logic [nnfs_pkg::DST_SZ_W-1:0]  dst_w_q, dst_h_q;
  logic                           func_q;
  logic [CW-1:0]                  x_q, y_q;
  logic [nnfs_pkg::PIX_W-1:0]     pix_q;
  logic [AW-1:0]                  clr_cnt_q;
  logic                           range_q;
  logic [nnfs_pkg::REM_W-1:0]     rem_q;
  logic [SW-1:0]                  num_q, quo_q, sx_q;
  logic [AW-1:0]                  addr_q;
  logic                           out_valid_q;
  logic                           out_range_q;
  logic [nnfs_pkg::PIX_W-1:0]     out_pix_q;

  logic [SW-1:0]                  sw_eff, sh_eff, mul_sz;
  logic [CW-1:0]                  mul_src;
  logic [nnfs_pkg::PROD_W-1:0]    prod;
  logic [nnfs_pkg::DST_SZ_W-1:0]  dvs;
  logic [nnfs_pkg::REM_W-1:0]     trial;
  logic                           in_dst, src_ok;
  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [nnfs_pkg::PIX_W-1:0]     ram_wdata, ram_rdata;

  assign sw_eff = eff_size(src_w_q, MAX_SRC_WIDTH);
  assign sh_eff = eff_size(src_h_q, MAX_SRC_HEIGHT);

  assign in_dst = (nnfs_pkg::DST_SZ_W'(x_q) < dst_w_q) && (nnfs_pkg::DST_SZ_W'(y_q) < dst_h_q);
  assign src_ok = (x_q < CW'(sw_eff)) && (y_q < CW'(sh_eff));

  assign mul_src = cmd_i.axis_y ? y_q : x_q;
  assign mul_sz  = cmd_i.axis_y ? sh_eff : sw_eff;
  assign prod    = nnfs_pkg::PROD_W'(mul_src) * nnfs_pkg::PROD_W'(mul_sz);
  assign dvs     = cmd_i.axis_y ? dst_h_q : dst_w_q;
  assign trial   = {rem_q[nnfs_pkg::REM_W-2:0], num_q[SW-1]};

  assign ram_we    = cmd_i.clear || (cmd_i.decode && (func_q == nnfs_pkg::FUNC_WRITE) && src_ok);
  assign ram_waddr = cmd_i.clear ? clr_cnt_q : lin_addr(y_q, x_q);
  assign ram_wdata = cmd_i.clear ? '0 : pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= nnfs_pkg::SRC_SZ_RST;
      src_h_q <= nnfs_pkg::SRC_SZ_RST;
      dst_w_q <= nnfs_pkg::DST_SZ_RST;
      dst_h_q <= nnfs_pkg::DST_SZ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nnfs_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[SW-1:0];
        nnfs_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[SW-1:0];
        nnfs_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        nnfs_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      x_q    <= coord_x_i;
      y_q    <= coord_y_i;
      pix_q  <= {nnfs_pkg::clamp_ch(red_in_i), nnfs_pkg::clamp_ch(green_in_i),
                 nnfs_pkg::clamp_ch(blue_in_i)};
    end
    if (cmd_i.decode) begin
      range_q <= in_dst;
    end
    if (cmd_i.mul_load) begin
      rem_q <= nnfs_pkg::REM_W'(prod[nnfs_pkg::PROD_W-1:SW]);
      num_q <= prod[SW-1:0];
      quo_q <= '0;
      if (cmd_i.axis_y) begin
        sx_q <= lim_idx(quo_q, sw_eff);
      end
    end else if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (trial >= nnfs_pkg::REM_W'(dvs)) begin
        rem_q <= trial - nnfs_pkg::REM_W'(dvs);
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
    if (cmd_i.addr_load) begin
      addr_q <= lin_addr(CW'(lim_idx(quo_q, sh_eff)), CW'(sx_q));
    end
    if (cmd_i.out_load) begin
      out_range_q <= range_q;
      out_pix_q   <= range_q ? ram_rdata : '0;
    end
  end

  nnfs_ram #(
    .WIDTH (nnfs_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign status_o.is_read    = (func_q == nnfs_pkg::FUNC_READ);
  assign status_o.in_dst     = in_dst;
  assign status_o.clear_last = (clr_cnt_q == AW'(DEPTH - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign in_range_o  = out_range_q;
  assign red_out_o   = out_pix_q[3*OW-1:2*OW];
  assign green_out_o = out_pix_q[2*OW-1:OW];
  assign blue_out_o  = out_pix_q[OW-1:0];

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_range_q) |-> (out_pix_q == '0))
    else $error("out-of-range result not black");
`endif

endmodule

FILE: hw/rtl/nnfs_ctrl.sv
// Controller: sequences store clearing, writes and the multiply/divide/read steps of a read.
module nnfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nnfs_pkg::dp_status_t  status_i,
  output nnfs_pkg::ctrl_cmd_t   cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_ADDR   = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  localparam logic [nnfs_pkg::STEP_W-1:0] STEP_LAST = nnfs_pkg::STEP_W'(nnfs_pkg::SRC_SZ_W - 1);

  logic [2:0]                    state_q, state_d;
  logic                          axis_q, axis_d;
  logic [nnfs_pkg::STEP_W-1:0]   step_q, step_d;

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.axis_y = axis_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        axis_d       = 1'b0;
        priority if (!status_i.is_read) begin
          state_d = S_IDLE;
        end else if (!status_i.in_dst) begin
          state_d = S_RESP;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + nnfs_pkg::STEP_W'(1);
        if (step_q == STEP_LAST) begin
          if (axis_q) begin
            state_d = S_ADDR;
          end else begin
            axis_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_ADDR: begin
        cmd_o.addr_load = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      axis_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && step_q == STEP_LAST && axis_q) |=> (state_q == S_ADDR))
    else $error("second division did not lead to address step");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the nearest-neighbor frame scaler: pixel writes and resampled reads.
module tb_top;
  import nnfs_pkg::*;

  localparam int unsigned STORE_DEPTH    = MAX_SRC_WIDTH_DEF * MAX_SRC_HEIGHT_DEF;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic                      func;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic signed [CH_IN_W-1:0] r;
    logic signed [CH_IN_W-1:0] g;
    logic signed [CH_IN_W-1:0] b;
  } pix_req_t;

  typedef struct {
    logic [CH_OUT_W-1:0] r;
    logic [CH_OUT_W-1:0] g;
    logic [CH_OUT_W-1:0] b;
    logic                in_range;
  } pix_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  nnfs_in_if  req_if ();
  nnfs_out_if rsp_if ();

  nearest_neighbor_frame_scaler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // frame mirror and register copies
  logic [PIX_W-1:0]    frame_mem [STORE_DEPTH];
  logic [SRC_SZ_W-1:0] cur_sw;
  logic [SRC_SZ_W-1:0] cur_sh;
  logic [DST_SZ_W-1:0] cur_dw;
  logic [DST_SZ_W-1:0] cur_dh;

  pix_req_t pend_q [$];
  pix_rsp_t resampled_q [$];
  int       items_left = 0;
  int       mismatch_cnt = 0;
  int       idle_cnt = 0;
  logic     req_taken = 1'b0;

  int          recent_x [16];
  int          recent_y [16];
  int          recent_n = 0;

  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_cnt = 0;
  int          pat_cnt = 0;
  int unsigned stall_pct = 0;

  int       burst_left = 0;
  int       gap_left = 0;
  pix_req_t nxt;

  function automatic int unsigned eff_src(logic [SRC_SZ_W-1:0] v, int unsigned maxv);
    if (v == '0) begin
      return 1;
    end
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic logic [CH_OUT_W-1:0] limit_channel(logic signed [CH_IN_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (int'(v) > (1 << CHANNEL_FRAC_BITS)) begin
      return CH_OUT_W'(1 << CHANNEL_FRAC_BITS);
    end
    return v[CH_OUT_W-1:0];
  endfunction

  function automatic pix_rsp_t nearest_pixel(int unsigned x, int unsigned y);
    pix_rsp_t    res;
    int unsigned sw;
    int unsigned sh;
    int unsigned sx;
    int unsigned sy;
    logic [PIX_W-1:0] px;
    sw = eff_src(cur_sw, MAX_SRC_WIDTH_DEF);
    sh = eff_src(cur_sh, MAX_SRC_HEIGHT_DEF);
    res = '{r: '0, g: '0, b: '0, in_range: 1'b0};
    if (x >= cur_dw || y >= cur_dh) begin
      return res;
    end
    sx = (x * sw) / cur_dw;
    sy = (y * sh) / cur_dh;
    if (sx > sw - 1) sx = sw - 1;
    if (sy > sh - 1) sy = sh - 1;
    px = frame_mem[sy * MAX_SRC_WIDTH_DEF + sx];
    res.r = px[3*CH_OUT_W-1:2*CH_OUT_W];
    res.g = px[2*CH_OUT_W-1:CH_OUT_W];
    res.b = px[CH_OUT_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  task automatic apply_request(pix_req_t it);
    if (it.func == FUNC_WRITE) begin
      if (it.x < eff_src(cur_sw, MAX_SRC_WIDTH_DEF) &&
          it.y < eff_src(cur_sh, MAX_SRC_HEIGHT_DEF)) begin
        frame_mem[it.y * MAX_SRC_WIDTH_DEF + it.x] =
          {limit_channel(it.r), limit_channel(it.g), limit_channel(it.b)};
      end
    end else begin
      resampled_q.push_back(nearest_pixel(it.x, it.y));
    end
  endtask

  task automatic report_bad(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endtask

  // monitor: prediction on accepted requests, check on accepted results, watchdog
  always @(posedge clk_i) begin
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        apply_request('{func: req_if.func, x: req_if.coord_x, y: req_if.coord_y,
                        r: req_if.red_in, g: req_if.green_in, b: req_if.blue_in});
        items_left--;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (resampled_q.size() == 0) begin
          report_bad($sformatf("unexpected item: r=%0d g=%0d b=%0d in=%0b",
                               rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out,
                               rsp_if.in_range));
        end else begin
          pix_rsp_t exp_px;
          exp_px = resampled_q.pop_front();
          if (exp_px.r !== rsp_if.red_out || exp_px.g !== rsp_if.green_out ||
              exp_px.b !== rsp_if.blue_out || exp_px.in_range !== rsp_if.in_range) begin
            report_bad($sformatf(
              "mismatch: exp r=%0d g=%0d b=%0d in=%0b got r=%0d g=%0d b=%0d in=%0b",
              exp_px.r, exp_px.g, exp_px.b, exp_px.in_range,
              rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out, rsp_if.in_range));
          end
        end
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("nearest_neighbor_frame_scaler regression: fail");
        $finish;
      end
    end
  end

  // request driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if (gap_left != 0 || pend_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        req_if.valid <= 1'b0;
      end else begin
        nxt = pend_q.pop_front();
        req_if.func     <= nxt.func;
        req_if.coord_x  <= nxt.x;
        req_if.coord_y  <= nxt.y;
        req_if.red_in   <= nxt.r;
        req_if.green_in <= nxt.g;
        req_if.blue_in  <= nxt.b;
        req_if.valid    <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
    end
  end

  // result receiver: own stall pattern plus long hold-offs on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      rsp_if.ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      hold_cnt = HOLD_CYCLES - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      if (pat_cnt == 0) begin
        pat_cnt = $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      pat_cnt--;
      rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_req(logic func, int x, int y, logic [15:0] r, logic [15:0] g,
                          logic [15:0] b);
    pend_q.push_back('{func: func, x: x[COORD_W-1:0], y: y[COORD_W-1:0],
                       r: r, g: g, b: b});
    items_left++;
  endtask

  function automatic logic [15:0] rand_channel();
    if ($urandom_range(0, 9) < 6) begin
      return 16'($urandom_range(0, 1 << CHANNEL_FRAC_BITS));
    end
    return 16'($urandom);
  endfunction

  task automatic add_random(int n);
    int unsigned sw;
    int unsigned sh;
    int unsigned x;
    int unsigned y;
    int unsigned k;
    int          pick;
    sw = eff_src(cur_sw, MAX_SRC_WIDTH_DEF);
    sh = eff_src(cur_sh, MAX_SRC_HEIGHT_DEF);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        x = $urandom_range(0, sw - 1);
        y = $urandom_range(0, sh - 1);
        recent_x[recent_n % 16] = x;
        recent_y[recent_n % 16] = y;
        recent_n++;
        push_req(FUNC_WRITE, x, y, rand_channel(), rand_channel(), rand_channel());
      end else if (pick < 8 && cur_dw != 0 && cur_dh != 0) begin
        if (recent_n != 0 && $urandom_range(0, 1) == 0) begin
          // aim at a recently written source pixel
          k = $urandom_range(0, (recent_n < 16 ? recent_n : 16) - 1);
          x = recent_x[k] > sw - 1 ? sw - 1 : recent_x[k];
          y = recent_y[k] > sh - 1 ? sh - 1 : recent_y[k];
          x = (x * cur_dw + sw - 1) / sw;
          y = (y * cur_dh + sh - 1) / sh;
          if (x >= cur_dw) x = cur_dw - 1;
          if (y >= cur_dh) y = cur_dh - 1;
        end else begin
          x = $urandom_range(0, cur_dw - 1);
          y = $urandom_range(0, cur_dh - 1);
        end
        if (x > 4095) x = 4095;
        if (y > 4095) y = 4095;
        push_req(FUNC_READ, x, y, 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        push_req(1'($urandom), $urandom_range(0, 4095), $urandom_range(0, 4095),
                 16'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (items_left != 0 || resampled_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_SRC_WIDTH:  cur_sw = data[SRC_SZ_W-1:0];
      REG_SRC_HEIGHT: cur_sh = data[SRC_SZ_W-1:0];
      REG_DST_WIDTH:  cur_dw = data[DST_SZ_W-1:0];
      default:        cur_dh = data[DST_SZ_W-1:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_frame(int sw, int sh, int dw, int dh);
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
    write_reg(REG_DST_WIDTH, CFG_DATA_W'(dw));
    write_reg(REG_DST_HEIGHT, CFG_DATA_W'(dh));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_SRC_WIDTH;
    cfg_data_i      = '0;
    req_if.valid    = 1'b0;
    req_if.func     = FUNC_WRITE;
    req_if.coord_x  = '0;
    req_if.coord_y  = '0;
    req_if.red_in   = '0;
    req_if.green_in = '0;
    req_if.blue_in  = '0;
    rsp_if.ready    = 1'b0;
    cur_sw = SRC_SZ_RST;
    cur_sh = SRC_SZ_RST;
    cur_dw = DST_SZ_RST;
    cur_dh = DST_SZ_RST;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: channel limits, frame corners, ignored writes, out-of-frame reads
    push_req(FUNC_READ,  0,    0,    16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_WRITE, 0,    0,    16'h7FFF, 16'h8000, 16'h4000);
    push_req(FUNC_WRITE, 255,  255,  16'h4001, 16'h3FFF, 16'hFFFF);
    push_req(FUNC_WRITE, 1,    0,    16'h2AAA, 16'h1555, 16'h0001);
    push_req(FUNC_WRITE, 256,  0,    16'h1111, 16'h1111, 16'h1111);
    push_req(FUNC_WRITE, 0,    256,  16'h2222, 16'h2222, 16'h2222);
    push_req(FUNC_WRITE, 4095, 4095, 16'h3333, 16'h3333, 16'h3333);
    push_req(FUNC_READ,  0,    0,    16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_req(FUNC_READ,  255,  255,  16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  1,    0,    16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  255,  0,    16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  0,    255,  16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  256,  0,    16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  0,    256,  16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_READ,  4095, 4095, 16'h0000, 16'h0000, 16'h0000);
    push_req(FUNC_WRITE, 255,  255,  16'h1234, 16'h0ABC, 16'h3000);
    push_req(FUNC_READ,  255,  255,  16'h0000, 16'h0000, 16'h0000);
    add_random(PHASE_ITEMS);
    wait_idle();

    set_frame(256, 256, 4096, 4096);
    hold_asked++;
    add_random(PHASE_ITEMS);
    wait_idle();

    set_frame(1, 1, 1, 1);
    add_random(PHASE_ITEMS);
    wait_idle();

    // zero source width, oversized source height, zero output height
    set_frame(0, 511, 8191, 0);
    add_random(PHASE_ITEMS);
    wait_idle();

    set_frame(17, 200, 5, 300);
    add_random(PHASE_ITEMS);
    wait_idle();

    set_frame(511, 0, 0, 8191);
    add_random(PHASE_ITEMS);
    wait_idle();

    set_frame(100, 37, 4095, 13);
    hold_asked++;
    add_random(PHASE_ITEMS);
    wait_idle();

    repeat (2) begin
      set_frame($urandom_range(1, 256), $urandom_range(1, 256),
                $urandom_range(1, 4096), $urandom_range(1, 4096));
      add_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (30) @(negedge clk_i);
    if (mismatch_cnt == 0 && resampled_q.size() == 0) begin
      $display("nearest_neighbor_frame_scaler regression: pass");
    end else begin
      $display("nearest_neighbor_frame_scaler regression: fail");
    end
    $finish;
  end

endmodule
